### rtl/temperature_to_seven_segment_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the temperature to seven-segment unit
// Concurrent assertion wrappers; they compile away in synthesis.
// ----------------------------------------------------------------------------
`ifndef TEMPERATURE_TO_SEVEN_SEGMENT_UNIT_MACROS_SVH
`define TEMPERATURE_TO_SEVEN_SEGMENT_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define TTS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Expression must never be true outside reset.
`define TTS_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`else

`define TTS_ASSERT(lbl, clk, rst_n, prop)
`define TTS_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

### rtl/tts_pkg.sv
// ----------------------------------------------------------------------------
// tts_pkg
// Types, constants and segment helpers shared by the display converter.
// ----------------------------------------------------------------------------
package tts_pkg;

    localparam int TEMP_W   = 24;   // input temperature, hundredths
    localparam int SEG_W    = 8;    // a..g, dp
    localparam int TENTHS_W = 20;   // rounded magnitude in tenths
    localparam int NUM_W    = 14;   // tenths value once known below 10000
    localparam int Q1_W     = 11;   // num / 10
    localparam int Q2_W     = 8;    // num / 100
    localparam int Q3_W     = 5;    // num / 1000
    localparam int PROD_W   = 30;

    // x / 10 for x below 2^24: (x * ceil(2^27/10)) >> 27
    localparam logic [TEMP_W-1:0] RCP_T_M = 24'd13421773;
    localparam int                RCP_T_S = 27;

    // reciprocals for the digit split, exact for num below 16384
    localparam logic [15:0] RCP_Q1_M = 16'd52429;  // 2^19 / 10
    localparam int          RCP_Q1_S = 19;
    localparam logic [15:0] RCP_Q2_M = 16'd10486;  // 2^20 / 100
    localparam int          RCP_Q2_S = 20;
    localparam logic [15:0] RCP_Q3_M = 16'd16778;  // 2^24 / 1000
    localparam int          RCP_Q3_S = 24;

    // range limits in tenths
    localparam logic [TENTHS_W-1:0] LIM_LOW   = 20'd995;
    localparam logic [TENTHS_W-1:0] LIM_100   = 20'd100;
    localparam logic [TENTHS_W-1:0] LIM_1000  = 20'd1000;
    localparam logic [TENTHS_W-1:0] LIM_10000 = 20'd10000;

    localparam logic [SEG_W-1:0] SEG_BLANK = 8'h00;
    localparam logic [SEG_W-1:0] SEG_MINUS = 8'h02;
    localparam logic [SEG_W-1:0] SEG_POINT = 8'h01;
    localparam logic [SEG_W-1:0] SEG_LOW   = 8'b0001_1100;
    localparam logic [SEG_W-1:0] SEG_HIGH  = 8'b0110_1110;

    typedef enum logic [2:0] {
        FMT_LOW,      // blank, L, blank
        FMT_NEG_INT,  // minus, tens, units
        FMT_NEG_DEC,  // minus, units., tenths
        FMT_DEC2,     // blank, units., tenths
        FMT_DEC3,     // tens, units., tenths
        FMT_INT,      // hundreds, tens, units
        FMT_HIGH      // blank, H, blank
    } t_fmt;

    typedef struct packed {
        logic                neg;
        logic [TENTHS_W-1:0] tenths;
    } t_round;

    typedef struct packed {
        t_fmt             fmt;
        logic [NUM_W-1:0] num;
        logic [Q1_W-1:0]  q1;
        logic [Q2_W-1:0]  q2;
        logic [Q3_W-1:0]  q3;
    } t_split;

    function automatic logic [SEG_W-1:0] seg_digit(input logic [3:0] d);
        logic [SEG_W-1:0] s;
        case (d)
            4'd0:    s = 8'hFC;
            4'd1:    s = 8'h60;
            4'd2:    s = 8'hDA;
            4'd3:    s = 8'hF2;
            4'd4:    s = 8'h66;
            4'd5:    s = 8'hB6;
            4'd6:    s = 8'hBE;
            4'd7:    s = 8'hE0;
            4'd8:    s = 8'hFE;
            4'd9:    s = 8'hF6;
            default: s = SEG_BLANK;
        endcase
        return s;
    endfunction

    // low nibble of q * 10, enough for a remainder known to be below 10
    function automatic logic [3:0] mul10_lo(input logic [3:0] q);
        logic [3:0] a;
        logic [3:0] b;
        a = {q[0], 3'b000};
        b = {q[2:0], 1'b0};
        return a + b;
    endfunction

endpackage

### rtl/temperature_to_seven_segment_unit.sv
// ----------------------------------------------------------------------------
// temperature_to_seven_segment_unit
// Signed temperature in hundredths to three seven-segment digit patterns.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake          | Payload
//  ---------+--------------------+-----------------------------------------
//  in       | i_valid / o_ready  | i_temp_hundredths (24b signed)
//  out      | o_valid / i_ready  | o_left/middle/right_segments (8b each)
//
//  One transaction in per cycle, one out per cycle, sustained while i_ready
//  is high. Stages: input register, round to tenths (one 24x24 multiply by
//  the reciprocal of 10), format select and digit quotients (three small
//  reciprocal multiplies), segment encode into the result reg.
//  The four stages advance together whenever the result register is empty
//  or being taken, so a stall on the output holds the whole pipe and drops
//  o_ready in the same cycle.
//  Reset (synchronous, active low) clears the stage valid bits only.
//
module temperature_to_seven_segment_unit import tts_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic signed [TEMP_W-1:0] i_temp_hundredths,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [SEG_W-1:0]         o_left_segments,
    output logic [SEG_W-1:0]         o_middle_segments,
    output logic [SEG_W-1:0]         o_right_segments
);

`include "temperature_to_seven_segment_unit_macros.svh"

    // stage valid bits: a = input reg, b = tenths, c = split, d = result
    logic   r_v_a;
    logic   r_v_b;
    logic   r_v_c;
    logic   r_v_d;
    logic   w_adv;
    t_round w_round;
    t_split w_split;

    // whole pipe moves when the result slot is free or drains this cycle
    assign w_adv   = !r_v_d || i_ready;
    assign o_ready = w_adv;
    assign o_valid = r_v_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_a <= 1'b0;
            r_v_b <= 1'b0;
            r_v_c <= 1'b0;
            r_v_d <= 1'b0;
        end else if (w_adv) begin
            r_v_a <= i_valid;
            r_v_b <= r_v_a;
            r_v_c <= r_v_b;
            r_v_d <= r_v_c;
        end
    end

    // input register and rounding (stages a and b)
    tts_round u_round (
        .i_clk             (i_clk),
        .i_load            (w_adv),
        .i_temp_hundredths (i_temp_hundredths),
        .o_round           (w_round)
    );

    // format decision and decimal quotients (stage c)
    tts_split u_split (
        .i_clk   (i_clk),
        .i_load  (w_adv),
        .i_round (w_round),
        .o_split (w_split)
    );

    // segment patterns into the result register (stage d)
    tts_encode u_encode (
        .i_clk    (i_clk),
        .i_load   (w_adv),
        .i_split  (w_split),
        .o_left   (o_left_segments),
        .o_middle (o_middle_segments),
        .o_right  (o_right_segments)
    );

    // a held result must block new input
    `TTS_NEVER(a_stall_blocks_input, i_clk, i_rst_n, o_valid && !i_ready && o_ready)
    // an accepted transaction lands in the input stage
    `TTS_ASSERT(a_accept_fills, i_clk, i_rst_n, (i_valid && o_ready) |=> r_v_a)
    // integer format only for values below 10000
    `TTS_NEVER(a_int_range, i_clk, i_rst_n, r_v_c && (w_split.fmt == FMT_INT) && (w_split.q3 > 5'd9))
    // three-digit decimal format only for values below 1000
    `TTS_NEVER(a_dec_range, i_clk, i_rst_n, r_v_c && (w_split.fmt == FMT_DEC3) && (w_split.num >= 14'd1000))

endmodule

### rtl/tts_round.sv
// ----------------------------------------------------------------------------
// tts_round
// Input register and half-up rounding of the magnitude to tenths.
// ----------------------------------------------------------------------------
module tts_round import tts_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_load,
    input  logic signed [TEMP_W-1:0] i_temp_hundredths,
    output t_round                   o_round
);

    logic              r_neg;
    logic [TEMP_W-1:0] r_sum;
    logic [TEMP_W-1:0] n_sum;
    logic [TEMP_W-1:0] w_mag;
    logic [2*TEMP_W-1:0] w_prod;
    t_round            r_round;
    t_round            n_round;

    // magnitude of 0x800000 is 2^23 and still fits unsigned
    always_comb begin
        w_mag = i_temp_hundredths[TEMP_W-1] ? (~i_temp_hundredths + 24'd1)
                                            : i_temp_hundredths;
        n_sum = w_mag + 24'd5;
    end

    always_comb begin
        w_prod         = {{TEMP_W{1'b0}}, r_sum} * {{TEMP_W{1'b0}}, RCP_T_M};
        n_round.neg    = r_neg;
        n_round.tenths = w_prod[RCP_T_S +: TENTHS_W];
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_neg   <= i_temp_hundredths[TEMP_W-1];
            r_sum   <= n_sum;
            r_round <= n_round;
        end
    end

    assign o_round = r_round;

endmodule

### rtl/tts_split.sv
// ----------------------------------------------------------------------------
// tts_split
// Picks the display format and takes the decimal quotients of the value.
// ----------------------------------------------------------------------------
module tts_split import tts_pkg::*; (
    input  logic   i_clk,
    input  logic   i_load,
    input  t_round i_round,
    output t_split o_split
);

    logic [NUM_W-1:0]  w_num;
    logic [PROD_W-1:0] w_p1;
    logic [PROD_W-1:0] w_p2;
    logic [PROD_W-1:0] w_p3;
    t_split            r_split;
    t_split            n_split;

    always_comb begin
        w_num = i_round.tenths[NUM_W-1:0];
        w_p1  = PROD_W'(w_num) * PROD_W'(RCP_Q1_M);
        w_p2  = PROD_W'(w_num) * PROD_W'(RCP_Q2_M);
        w_p3  = PROD_W'(w_num) * PROD_W'(RCP_Q3_M);

        n_split.num = w_num;
        n_split.q1  = w_p1[RCP_Q1_S +: Q1_W];
        n_split.q2  = w_p2[RCP_Q2_S +: Q2_W];
        n_split.q3  = w_p3[RCP_Q3_S +: Q3_W];

        // negative zero falls through to the positive formats
        if (i_round.neg && (i_round.tenths != '0)) begin
            if (i_round.tenths >= LIM_LOW) begin
                n_split.fmt = FMT_LOW;
            end else if (i_round.tenths >= LIM_100) begin
                n_split.fmt = FMT_NEG_INT;
            end else begin
                n_split.fmt = FMT_NEG_DEC;
            end
        end else if (i_round.tenths < LIM_100) begin
            n_split.fmt = FMT_DEC2;
        end else if (i_round.tenths < LIM_1000) begin
            n_split.fmt = FMT_DEC3;
        end else if (i_round.tenths < LIM_10000) begin
            n_split.fmt = FMT_INT;
        end else begin
            n_split.fmt = FMT_HIGH;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_split <= n_split;
        end
    end

    assign o_split = r_split;

endmodule

### rtl/tts_encode.sv
// ----------------------------------------------------------------------------
// tts_encode
// Decimal digits to segment patterns, held in the result register.
// ----------------------------------------------------------------------------
module tts_encode import tts_pkg::*; (
    input  logic             i_clk,
    input  logic             i_load,
    input  t_split           i_split,
    output logic [SEG_W-1:0] o_left,
    output logic [SEG_W-1:0] o_middle,
    output logic [SEG_W-1:0] o_right
);

    logic [3:0]       w_d0;
    logic [3:0]       w_d1;
    logic [3:0]       w_d2;
    logic [3:0]       w_d3;
    logic [SEG_W-1:0] r_left;
    logic [SEG_W-1:0] r_middle;
    logic [SEG_W-1:0] r_right;
    logic [SEG_W-1:0] n_left;
    logic [SEG_W-1:0] n_middle;
    logic [SEG_W-1:0] n_right;

    always_comb begin
        // remainders are below 10, so four bits of arithmetic suffice
        w_d0 = i_split.num[3:0] - mul10_lo(i_split.q1[3:0]);
        w_d1 = i_split.q1[3:0]  - mul10_lo(i_split.q2[3:0]);
        w_d2 = i_split.q2[3:0]  - mul10_lo(i_split.q3[3:0]);
        w_d3 = i_split.q3[3:0];

        case (i_split.fmt)
            FMT_LOW: begin
                n_left   = SEG_BLANK;
                n_middle = SEG_LOW;
                n_right  = SEG_BLANK;
            end
            FMT_NEG_INT: begin
                n_left   = SEG_MINUS;
                n_middle = seg_digit(w_d2);
                n_right  = seg_digit(w_d1);
            end
            FMT_NEG_DEC: begin
                n_left   = SEG_MINUS;
                n_middle = seg_digit(w_d1) | SEG_POINT;
                n_right  = seg_digit(w_d0);
            end
            FMT_DEC2: begin
                n_left   = SEG_BLANK;
                n_middle = seg_digit(w_d1) | SEG_POINT;
                n_right  = seg_digit(w_d0);
            end
            FMT_DEC3: begin
                n_left   = seg_digit(w_d2);
                n_middle = seg_digit(w_d1) | SEG_POINT;
                n_right  = seg_digit(w_d0);
            end
            FMT_INT: begin
                n_left   = seg_digit(w_d3);
                n_middle = seg_digit(w_d2);
                n_right  = seg_digit(w_d1);
            end
            FMT_HIGH: begin
                n_left   = SEG_BLANK;
                n_middle = SEG_HIGH;
                n_right  = SEG_BLANK;
            end
            default: begin
                n_left   = SEG_BLANK;
                n_middle = SEG_BLANK;
                n_right  = SEG_BLANK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_left   <= n_left;
            r_middle <= n_middle;
            r_right  <= n_right;
        end
    end

    assign o_left   = r_left;
    assign o_middle = r_middle;
    assign o_right  = r_right;

endmodule
